>>> hdl/adcbat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcbat_pkg
// Shared widths, conversion constants and the controller state type for the
// ADC block-average temperature core.
// ----------------------------------------------------------------------------
package adcbat_pkg;

    localparam int CODE_W     = 12;   // converter code
    localparam int TEMP_W     = 20;   // signed Q.8 temperature
    localparam int SLOT_OUT_W = 4;    // reported history slot
    localparam int FILL_OUT_W = 5;    // reported valid count

    // floor(code * 337920 / 4095) as a multiplication by a rounded-up
    // reciprocal and a right shift by 21. The rounding error stays below one
    // part in 273 over all 12-bit codes, so the quotient is exact.
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 21;
    localparam logic [RECIP_W-1:0] RECIP_NUM = 28'd173057291;
    localparam int PROD_W = CODE_W + RECIP_W;
    localparam int QUOT_W = 19;       // scaled quotient is at most 337920
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 20'sd71424;

    // Mean divider: the numerator holds a block sum of up to 4096 full-scale
    // codes.
    localparam int NUM_W  = 24;
    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic [5:0] {
        S_ACC   = 6'b000001,
        S_DIV   = 6'b000010,
        S_MUL   = 6'b000100,
        S_WRITE = 6'b001000,
        S_READ  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

endpackage
`default_nettype wire

>>> hdl/adc_block_average_temperature_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_block_average_temperature_core
// Averages blocks of converter samples and converts the mean code to a
// signed Q.8 temperature, keeping the results in a history ring.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  ------------------------
//  input     in         i_in_valid / o_in_stall       i_adc_sample, i_last_sample
//  result    out        o_out_valid / i_out_stall     o_temperature_q8,
//                                                     o_average_code,
//                                                     o_slot_written,
//                                                     o_valid_count
//
// A sample that does not close its block is taken at once, and the next
// sample may follow in the very next cycle. A closing sample holds the input
// stalled while its result is formed: the restoring divider resolves one bit
// of the mean per cycle, a multiply step then scales the mean by a fixed
// reciprocal to give the temperature, and the history memory is written and
// read back through its single port before the result word is loaded. The
// result register waits for as long as i_out_stall is held, while
// accumulation of the next block carries on; a further closing sample then
// waits in the last step, with the input stalled, until the register is
// free. Reset is synchronous and active low; it clears the accumulator,
// slot, fill count and the control state. The history memory is not
// cleared, so reset does not need to walk through it.
//
module adc_block_average_temperature_core #(
    parameter int HISTORY_DEPTH = 16,
    parameter int MAX_BLOCK     = 256
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic [adcbat_pkg::CODE_W-1:0]          i_adc_sample,
    input  wire logic                                   i_last_sample,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [adcbat_pkg::TEMP_W-1:0]        o_temperature_q8,
    output logic [adcbat_pkg::CODE_W-1:0]               o_average_code,
    output logic [adcbat_pkg::SLOT_OUT_W-1:0]           o_slot_written,
    output logic [adcbat_pkg::FILL_OUT_W-1:0]           o_valid_count
);
    import adcbat_pkg::*;

    // The block sum never exceeds MAX_BLOCK full-scale codes.
    localparam int SUM_W  = $clog2(MAX_BLOCK * 4095 + 1);
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int DEN_W  = CNT_W;
    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_BLOCK);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(HISTORY_DEPTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

    t_state r_state;

    // Block accumulator.
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_count;

    // Restoring divider for the mean. The quotient shifts in behind the
    // numerator.
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W:0]    w_trial;
    logic              w_qbit;
    logic [DEN_W-1:0]  n_rem;

    logic [CODE_W-1:0]        r_mean;
    logic [PROD_W-1:0]        w_prod;
    logic signed [TEMP_W-1:0] r_temp;

    // History ring and its bookkeeping.
    logic signed [TEMP_W-1:0] r_ring [HISTORY_DEPTH];
    logic signed [TEMP_W-1:0] r_rd_data;
    logic [SLOT_W-1:0]        r_slot;
    logic [SLOT_W-1:0]        r_slot_wr;
    logic [FILL_W-1:0]        r_fill;

    logic w_in_take;
    logic w_out_load;
    logic [SLOT_W+SLOT_OUT_W-1:0] w_slot_ext;
    logic [FILL_W+FILL_OUT_W-1:0] w_fill_ext;

    assign o_in_stall = (r_state != S_ACC);
    assign w_in_take  = i_in_valid && (r_state == S_ACC);
    assign w_out_load = (r_state == S_OUT) && (!o_out_valid || !i_out_stall);

    // Samples beyond the maximum block length are dropped, the closing mark
    // is still honoured.
    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        if (r_count < MAX_CNT) begin
            n_sum   = r_sum + SUM_W'(i_adc_sample);
            n_count = r_count + CNT_W'(1);
        end
    end

    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_den});
        if (w_qbit) begin
            n_rem = DEN_W'(w_trial - {1'b0, r_den});
        end else begin
            n_rem = w_trial[DEN_W-1:0];
        end
    end

    // Mean scaled by 337920 / 4095 through the fixed reciprocal.
    assign w_prod = PROD_W'(r_mean) * PROD_W'(RECIP_NUM);

    // Control state, accumulator and ring pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_sum       <= '0;
            r_count     <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_ACC: begin
                    if (w_in_take) begin
                        if (i_last_sample) begin
                            r_sum   <= '0;
                            r_count <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_sum   <= n_sum;
                            r_count <= n_count;
                        end
                    end
                end
                S_DIV: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
                    if (r_fill < FULL_FILL) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

    // Divider datapath and conversion results.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_ACC: begin
                r_num  <= NUM_W'(n_sum);
                r_den  <= DEN_W'(n_count);
                r_rem  <= '0;
                r_step <= '0;
            end
            S_DIV: begin
                r_num  <= {r_num[NUM_W-2:0], w_qbit};
                r_rem  <= n_rem;
                r_step <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    if (r_den == '0) begin
                        r_mean <= '0;
                    end else begin
                        r_mean <= {r_num[CODE_W-2:0], w_qbit};
                    end
                end
            end
            S_MUL: begin
                r_temp <= $signed({1'b0, w_prod[RECIP_SHIFT +: QUOT_W]}) - TEMP_OFFSET;
            end
            S_WRITE: begin
                r_slot_wr <= r_slot;
            end
            default: begin
            end
        endcase
    end

    // History memory: written once per block, read back to form the word.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_ring[r_slot] <= r_temp;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_ring[r_slot_wr];
        end
    end

    assign w_slot_ext = {{SLOT_OUT_W{1'b0}}, r_slot_wr};
    assign w_fill_ext = {{FILL_OUT_W{1'b0}}, r_fill};

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_temperature_q8 <= r_rd_data;
            o_average_code   <= r_mean;
            o_slot_written   <= w_slot_ext[SLOT_OUT_W-1:0];
            o_valid_count    <= w_fill_ext[FILL_OUT_W-1:0];
        end
    end

endmodule
`default_nettype wire
